### hw/rtl/tksel_pkg.sv
// Shared types and constants for the streaming top-k selector.
// No dependencies; compiled first.
package tksel_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int SCORE_W     = 32;
   localparam int TAG_W       = 16;
   localparam int KLIM_W      = 5;
   localparam logic [KLIM_W-1:0] K_LIMIT_RESET = 5'd10;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-3:0] REG_K_LIMIT = '0;

   localparam logic CMD_OFFER = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // per-cycle operation broadcast to every cell
   localparam logic [1:0] OP_HOLD    = 2'd0;
   localparam logic [1:0] OP_INSERT  = 2'd1;
   localparam logic [1:0] OP_REPLACE = 2'd2;
   localparam logic [1:0] OP_SHIFT   = 2'd3;

   typedef struct packed {
      logic [1:0]                op;
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          tag;
   } cell_ctrl_type;

   typedef struct packed {
      logic                      valid;
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          tag;
   } cell_state_type;

endpackage

### hw/rtl/tksel_if.sv
// Valid/ready stream interfaces for the request and response channels.
// Depends on tksel_pkg.
interface tksel_req_if;
   logic                                valid;
   logic                                ready;
   logic                                cmd;
   logic signed [tksel_pkg::SCORE_W-1:0] score;
   logic [tksel_pkg::TAG_W-1:0]          tag;

   modport source (output valid, output cmd, output score, output tag, input ready);
   modport sink   (input valid, input cmd, input score, input tag, output ready);
endinterface

interface tksel_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [tksel_pkg::SCORE_W-1:0] out_score;
   logic [tksel_pkg::TAG_W-1:0]          out_tag;
   logic                                last;

   modport source (output valid, output out_score, output out_tag, output last, input ready);
   modport sink   (input valid, input out_score, input out_tag, input last, output ready);
endinterface

### hw/rtl/tksel_cell.sv
// One slot of the sorted chain: holds one entry, trades with its neighbors.
// Depends on tksel_pkg.
module tksel_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  tksel_pkg::cell_ctrl_type  ctrl,
   input  tksel_pkg::cell_state_type left_st,
   input  logic                      left_le,
   input  tksel_pkg::cell_state_type right_st,
   input  logic                      right_le,
   output tksel_pkg::cell_state_type st,
   output logic                      le
);
   import tksel_pkg::*;

   cell_state_type st_ff, st_in;

   assign st = st_ff;
   // held score not above the offered one
   assign le = st_ff.valid && (st_ff.score <= ctrl.score);

   always_comb begin
      st_in = st_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (le) begin
               st_in = st_ff;
            end else if (left_le) begin
               st_in = '{valid: 1'b1, score: ctrl.score, tag: ctrl.tag};
            end else begin
               st_in = left_st;
            end
         end
         OP_REPLACE: begin
            if (right_le) begin
               st_in = right_st;
            end else if (le) begin
               st_in = '{valid: 1'b1, score: ctrl.score, tag: ctrl.tag};
            end else begin
               st_in = st_ff;
            end
         end
         OP_SHIFT: st_in = right_st;
         default:  st_in = st_ff;
      endcase
   end

   // only the valid bit is reset; score and tag are dont-care while invalid
   always_ff @(posedge clock) begin
      st_ff.score <= st_in.score;
      st_ff.tag   <= st_in.tag;
      if (reset) begin
         st_ff.valid <= 1'b0;
      end else begin
         st_ff.valid <= st_in.valid;
      end
   end

endmodule

### hw/rtl/tksel_chain.sv
// Row of MAX_ENTRIES cells, ascending by score from the head.
// Depends on tksel_pkg and tksel_cell.
module tksel_chain (
   input  logic                      clock,
   input  logic                      reset,
   input  tksel_pkg::cell_ctrl_type  ctrl,
   output tksel_pkg::cell_state_type head
);
   import tksel_pkg::*;

   cell_state_type st [MAX_ENTRIES];
   logic           le [MAX_ENTRIES];

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      cell_state_type left_st, right_st;
      logic           left_le, right_le;

      if (i == 0) begin : g_head
         // new entry enters the head when nothing below it
         assign left_st = '{valid: 1'b1, score: ctrl.score, tag: ctrl.tag};
         assign left_le = 1'b1;
      end else begin : g_mid_l
         assign left_st = st[i-1];
         assign left_le = le[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_tail
         assign right_st = '{valid: 1'b0, score: ctrl.score, tag: ctrl.tag};
         assign right_le = 1'b0;
      end else begin : g_mid_r
         assign right_st = st[i+1];
         assign right_le = le[i+1];
      end

      tksel_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .left_st  (left_st),
         .left_le  (left_le),
         .right_st (right_st),
         .right_le (right_le),
         .st       (st[i]),
         .le       (le[i])
      );
   end

   assign head = st[0];

endmodule

### hw/rtl/tksel_csr.sv
// APB-style register block holding k_limit.
// Depends on tksel_pkg.
module tksel_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tksel_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [tksel_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [tksel_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready,
   output logic [tksel_pkg::KLIM_W-1:0]          k_limit
);
   import tksel_pkg::*;

   logic [KLIM_W-1:0] k_limit_ff, k_limit_in;
   logic              sel_k;

   assign sel_k      = (csr_paddr[CSR_ADDR_W-1:2] == REG_K_LIMIT);
   assign csr_pready = 1'b1;
   assign k_limit    = k_limit_ff;
   assign csr_prdata = sel_k ? CSR_DATA_W'(k_limit_ff) : '0;

   always_comb begin
      k_limit_in = k_limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_k) begin
         k_limit_in = csr_pwdata[KLIM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_limit_ff <= K_LIMIT_RESET;
      end else begin
         k_limit_ff <= k_limit_in;
      end
   end

endmodule

### hw/rtl/streaming_top_k_selector_unit.sv
// Streaming top-k selector: one offer word per cycle while no flush drains.
// A flush of n held entries drains its n words from the head of the
// cell chain, first word valid the cycle after the flush is taken; requests
// stall until the word marked last is taken. An empty flush yields nothing.
// Reset (synchronous, active high) empties the chain and sets k_limit to 10.
module streaming_top_k_selector_unit (
   input  logic                             clock,
   input  logic                             reset,
   tksel_req_if.sink                        req,
   tksel_rsp_if.source                      rsp,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tksel_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tksel_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tksel_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import tksel_pkg::*;

   localparam logic ST_COLLECT = 1'b0;
   localparam logic ST_DRAIN   = 1'b1;

   logic              state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [KLIM_W-1:0] k_limit;
   logic [31:0]       k_eff;
   logic              full;
   logic              beats_head;
   logic              req_take, rsp_take;
   cell_ctrl_type     ctrl;
   cell_state_type    head;

   tksel_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .k_limit     (k_limit)
   );

   tksel_chain u_chain (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .head  (head)
   );

   // k of zero acts as one; k above chain depth is capped by the depth check
   assign k_eff = (k_limit == '0) ? 32'd1 : 32'(k_limit);
   assign full  = (32'(count_ff) >= k_eff) || (32'(count_ff) >= 32'(MAX_ENTRIES));

   // strict compare: a tie with the smallest held score is dropped
   assign beats_head = head.valid && (req.score > head.score);

   assign req.ready = (state_ff == ST_COLLECT);
   assign req_take  = req.valid && req.ready;

   // drain straight off the head cell; it is a register
   assign rsp.valid     = (state_ff == ST_DRAIN);
   assign rsp.out_score = head.score;
   assign rsp.out_tag   = head.tag;
   assign rsp.last      = (count_ff == CNT_W'(1));
   assign rsp_take      = rsp.valid && rsp.ready;

   always_comb begin
      ctrl.op    = OP_HOLD;
      ctrl.score = req.score;
      ctrl.tag   = req.tag;
      state_in   = state_ff;
      count_in   = count_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (req_take) begin
               if (req.cmd == CMD_FLUSH) begin
                  if (count_ff != '0) begin
                     state_in = ST_DRAIN;
                  end
               end else if (!full) begin
                  ctrl.op  = OP_INSERT;
                  count_in = count_ff + CNT_W'(1);
               end else if (beats_head) begin
                  // evict smallest, count unchanged
                  ctrl.op = OP_REPLACE;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_take) begin
               ctrl.op  = OP_SHIFT;
               count_in = count_ff - CNT_W'(1);
               if (rsp.last) begin
                  state_in = ST_COLLECT;
               end
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

### hw/rtl/tksel_checker.sv
// Port-level checks for the top-k selector, bound to the top level.
// Depends on streaming_top_k_selector_unit and its interfaces.
module tksel_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last
);

   // a word offered stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped before taken");

   // no request taken while a flush drains
   a_no_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready during drain");

   // drain has no gaps before last
   a_drain_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("drain stopped before last word");

   // nothing follows the last word, intake reopens
   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid && req_ready)
      else $error("drain continued past last word");

endmodule

bind streaming_top_k_selector_unit tksel_checker u_tksel_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_last  (rsp.last)
);
